// File: design/sgai_pkg.sv
// shared types and constants for the spatial grid actor index
`timescale 1ns / 1ps

package sgai_pkg;

    localparam int SLOT_W          = 6;
    localparam int POS_W           = 24;
    localparam int CELL_W          = 13;
    localparam int MAX_ACTORS_DEF  = 64;

    // floor(raw / 2560) = floor(floor(raw / 512) / 5)
    localparam int DIV_SHIFT       = 9;
    localparam int COARSE_W        = POS_W - DIV_SHIFT;
    localparam int DIV_OPND_W      = 16;
    localparam int DIV_PROD_W      = 2 * DIV_OPND_W;
    localparam logic [DIV_OPND_W-1:0] DIV_OFFSET = 16'd16385;  // 5 * 3277
    localparam logic [DIV_OPND_W-1:0] DIV_RECIP  = 16'hCCCD;   // 2^18 / 5, rounded up
    localparam int DIV_QSHIFT      = 18;
    localparam logic [CELL_W-1:0] CELL_BIAS = 13'd3277;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPD_X,
        ST_UPD_Y,
        ST_UPD_DONE,
        ST_QRY_SCAN,
        ST_QRY_END
    } state_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } tbl_ctl_t;

    typedef struct packed {
        logic                     present;
        logic signed [CELL_W-1:0] cell_x;
        logic signed [CELL_W-1:0] cell_y;
    } tbl_rd_t;

endpackage

// File: design/spatial_grid_actor_index_unit.sv
// top level of the uniform-grid actor index
`timescale 1ns / 1ps

// Uniform-grid actor index. An update (opcode 0) maps a Q15.8 position to the
// 10 m grid cell floor(pos/10) on each axis, records it for the actor slot and
// returns one result with first_seen / changed_cell; slots at or above
// MAX_ACTORS are not stored but still answered. A query (opcode 1) returns
// every stored actor in the named cell in ascending slot order, the last one
// marked, or a single cell_empty result. One item is taken at a time: an update
// holds s_ready low through states ST_UPD_X, ST_UPD_Y and ST_UPD_DONE, using the
// shared cell divider once per axis; a query holds it low through ST_QRY_SCAN, with
// the table's single read port visiting one slot per cycle unless a hit stalls on
// m_ready, and ST_QRY_END. A result that waits on m_ready keeps it low. The
// result register lets the next item be taken while the final result still
// waits. Storage needs no clearing after reset.
module spatial_grid_actor_index_unit
    import sgai_pkg::*;
#(
    parameter int MAX_ACTORS = MAX_ACTORS_DEF
)(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_opcode,
    input  logic [SLOT_W-1:0]        s_actor_slot,
    input  logic signed [POS_W-1:0]  s_pos_x,
    input  logic signed [POS_W-1:0]  s_pos_y,
    input  logic signed [CELL_W-1:0] s_query_cell_x,
    input  logic signed [CELL_W-1:0] s_query_cell_y,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [SLOT_W-1:0]        m_member_slot,
    output logic signed [CELL_W-1:0] m_cell_x,
    output logic signed [CELL_W-1:0] m_cell_y,
    output logic                     m_first_seen,
    output logic                     m_changed_cell,
    output logic                     m_cell_empty,
    output logic                     m_last_result
);

    localparam int AW    = $clog2(MAX_ACTORS);
    localparam int CNT_W = $clog2(MAX_ACTORS + 1);

    logic                     div_en;
    logic signed [POS_W-1:0]  div_pos;
    logic signed [CELL_W-1:0] div_cell;
    tbl_ctl_t                 tbl_ctl;
    tbl_rd_t                  tbl_rd;
    logic [AW-1:0]            tbl_rd_addr;
    logic [AW-1:0]            tbl_wr_addr;
    logic signed [CELL_W-1:0] tbl_wr_cell_x;
    logic signed [CELL_W-1:0] tbl_wr_cell_y;

    sgai_cell_div u_div (
        .aclk     (aclk),
        .en       (div_en),
        .pos      (div_pos),
        .cell_idx (div_cell)
    );

    sgai_slot_table #(
        .MAX_ACTORS (MAX_ACTORS),
        .AW         (AW)
    ) u_table (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (tbl_ctl),
        .rd_addr   (tbl_rd_addr),
        .wr_addr   (tbl_wr_addr),
        .wr_cell_x (tbl_wr_cell_x),
        .wr_cell_y (tbl_wr_cell_y),
        .rd        (tbl_rd)
    );

    sgai_ctrl #(
        .MAX_ACTORS (MAX_ACTORS),
        .AW         (AW),
        .CNT_W      (CNT_W)
    ) u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_actor_slot   (s_actor_slot),
        .s_pos_x        (s_pos_x),
        .s_pos_y        (s_pos_y),
        .s_query_cell_x (s_query_cell_x),
        .s_query_cell_y (s_query_cell_y),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_member_slot  (m_member_slot),
        .m_cell_x       (m_cell_x),
        .m_cell_y       (m_cell_y),
        .m_first_seen   (m_first_seen),
        .m_changed_cell (m_changed_cell),
        .m_cell_empty   (m_cell_empty),
        .m_last_result  (m_last_result),
        .div_en         (div_en),
        .div_pos        (div_pos),
        .div_cell       (div_cell),
        .tbl_ctl        (tbl_ctl),
        .tbl_rd_addr    (tbl_rd_addr),
        .tbl_wr_addr    (tbl_wr_addr),
        .tbl_wr_cell_x  (tbl_wr_cell_x),
        .tbl_wr_cell_y  (tbl_wr_cell_y),
        .tbl_rd         (tbl_rd)
    );

    // one item at a time
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while an item is in progress");

    // while idle, only a final result can still be waiting
    a_idle_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready && m_valid |-> m_last_result)
        else $error("idle with a non-final result pending");

    // update flags and the empty flag never mix
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_first_seen || m_changed_cell) |-> m_last_result && !m_cell_empty
            && !(m_first_seen && m_changed_cell))
        else $error("inconsistent result flags");

endmodule

// File: design/sgai_cell_div.sv
// shared position-to-cell divider, floor(raw / 2560) with a registered reciprocal multiply
`timescale 1ns / 1ps

module sgai_cell_div
    import sgai_pkg::*;
(
    input  logic                     aclk,
    input  logic                     en,
    input  logic signed [POS_W-1:0]  pos,
    output logic signed [CELL_W-1:0] cell_idx
);

    logic signed [COARSE_W-1:0] coarse;
    logic [DIV_OPND_W-1:0]      biased;
    logic [DIV_PROD_W-1:0]      prod_reg;
    logic [DIV_PROD_W-1:0]      prod_next;

    assign coarse = pos[POS_W-1:DIV_SHIFT];
    // bias keeps the operand positive so the reciprocal gives the floor
    assign biased = {{(DIV_OPND_W-COARSE_W){coarse[COARSE_W-1]}}, coarse} + DIV_OFFSET;
    assign prod_next = biased * DIV_RECIP;

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
        end
    end

    assign cell_idx = signed'(prod_reg[DIV_QSHIFT+CELL_W-1:DIV_QSHIFT] - CELL_BIAS);

endmodule

// File: design/sgai_slot_table.sv
// actor slot table: presence bits in flops and cell memory with registered read
`timescale 1ns / 1ps

module sgai_slot_table
    import sgai_pkg::*;
#(
    parameter int MAX_ACTORS = MAX_ACTORS_DEF,
    parameter int AW         = $clog2(MAX_ACTORS)
)(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  tbl_ctl_t                 ctl,
    input  logic [AW-1:0]            rd_addr,
    input  logic [AW-1:0]            wr_addr,
    input  logic signed [CELL_W-1:0] wr_cell_x,
    input  logic signed [CELL_W-1:0] wr_cell_y,
    output tbl_rd_t                  rd
);

    logic [MAX_ACTORS-1:0]     present_reg;
    logic [2*CELL_W-1:0]       cell_mem [MAX_ACTORS];
    logic [2*CELL_W-1:0]       rd_data_reg;
    logic                      rd_present_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            present_reg <= '0;
        end else if (ctl.wr_en) begin
            present_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            cell_mem[wr_addr] <= {wr_cell_x, wr_cell_y};
        end
    end

    // read data holds while rd_en is low
    always_ff @(posedge aclk) begin
        if (ctl.rd_en) begin
            rd_data_reg    <= cell_mem[rd_addr];
            rd_present_reg <= present_reg[rd_addr];
        end
    end

    assign rd.present = rd_present_reg;
    assign rd.cell_x  = signed'(rd_data_reg[2*CELL_W-1:CELL_W]);
    assign rd.cell_y  = signed'(rd_data_reg[CELL_W-1:0]);

endmodule

// File: design/sgai_ctrl.sv
// sequencer: update and query flow, table scan and result register
`timescale 1ns / 1ps

module sgai_ctrl
    import sgai_pkg::*;
#(
    parameter int MAX_ACTORS = MAX_ACTORS_DEF,
    parameter int AW         = $clog2(MAX_ACTORS),
    parameter int CNT_W      = $clog2(MAX_ACTORS + 1)
)(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_opcode,
    input  logic [SLOT_W-1:0]        s_actor_slot,
    input  logic signed [POS_W-1:0]  s_pos_x,
    input  logic signed [POS_W-1:0]  s_pos_y,
    input  logic signed [CELL_W-1:0] s_query_cell_x,
    input  logic signed [CELL_W-1:0] s_query_cell_y,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [SLOT_W-1:0]        m_member_slot,
    output logic signed [CELL_W-1:0] m_cell_x,
    output logic signed [CELL_W-1:0] m_cell_y,
    output logic                     m_first_seen,
    output logic                     m_changed_cell,
    output logic                     m_cell_empty,
    output logic                     m_last_result,
    output logic                     div_en,
    output logic signed [POS_W-1:0]  div_pos,
    input  logic signed [CELL_W-1:0] div_cell,
    output tbl_ctl_t                 tbl_ctl,
    output logic [AW-1:0]            tbl_rd_addr,
    output logic [AW-1:0]            tbl_wr_addr,
    output logic signed [CELL_W-1:0] tbl_wr_cell_x,
    output logic signed [CELL_W-1:0] tbl_wr_cell_y,
    input  tbl_rd_t                  tbl_rd
);

    state_t state_reg, state_next;

    logic                     op_reg;
    logic [SLOT_W-1:0]        slot_reg;
    logic signed [POS_W-1:0]  pos_x_reg;
    logic signed [POS_W-1:0]  pos_y_reg;
    logic signed [CELL_W-1:0] qx_reg;
    logic signed [CELL_W-1:0] qy_reg;
    logic signed [CELL_W-1:0] cx_reg;

    logic [CNT_W-1:0]         iss_cnt_reg;
    logic                     cmp_vld_reg;
    logic [AW-1:0]            cmp_idx_reg;
    logic                     pend_vld_reg;
    logic [AW-1:0]            pend_idx_reg;

    logic                     m_valid_reg;
    logic [SLOT_W-1:0]        m_slot_reg;
    logic signed [CELL_W-1:0] m_cx_reg;
    logic signed [CELL_W-1:0] m_cy_reg;
    logic                     m_fs_reg;
    logic                     m_ch_reg;
    logic                     m_em_reg;
    logic                     m_last_reg;

    logic                     accept;
    logic                     out_free;
    logic                     slot_ok;
    logic                     hit;
    logic                     stall;
    logic                     issue;
    logic                     scan_done;

    logic                     out_load;
    logic [SLOT_W-1:0]        o_slot;
    logic signed [CELL_W-1:0] o_cx;
    logic signed [CELL_W-1:0] o_cy;
    logic                     o_fs;
    logic                     o_ch;
    logic                     o_em;
    logic                     o_last;

    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign slot_ok   = {1'b0, slot_reg} < (SLOT_W+1)'(MAX_ACTORS);
    assign hit       = cmp_vld_reg && tbl_rd.present &&
                       (tbl_rd.cell_x == qx_reg) && (tbl_rd.cell_y == qy_reg);
    // a second hit must wait until the held one can go out
    assign stall     = hit && pend_vld_reg && !out_free;
    assign issue     = !stall && (iss_cnt_reg < CNT_W'(MAX_ACTORS));
    assign scan_done = (iss_cnt_reg == CNT_W'(MAX_ACTORS)) && !cmp_vld_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = (s_opcode == OP_QUERY) ? ST_QRY_SCAN : ST_UPD_X;
                end
            end
            ST_UPD_X:    state_next = ST_UPD_Y;
            ST_UPD_Y:    state_next = ST_UPD_DONE;
            ST_UPD_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_QRY_SCAN: begin
                if (scan_done) begin
                    state_next = ST_QRY_END;
                end
            end
            ST_QRY_END: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_ready       = 1'b0;
        div_en        = 1'b0;
        div_pos       = pos_x_reg;
        tbl_ctl       = '0;
        tbl_rd_addr   = slot_reg[AW-1:0];
        tbl_wr_addr   = slot_reg[AW-1:0];
        tbl_wr_cell_x = cx_reg;
        tbl_wr_cell_y = div_cell;
        out_load      = 1'b0;
        o_slot        = slot_reg;
        o_cx          = cx_reg;
        o_cy          = div_cell;
        o_fs          = 1'b0;
        o_ch          = 1'b0;
        o_em          = 1'b0;
        o_last        = 1'b1;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_UPD_X: begin
                div_en        = 1'b1;
                tbl_ctl.rd_en = 1'b1;
            end
            ST_UPD_Y: begin
                div_en  = 1'b1;
                div_pos = pos_y_reg;
            end
            ST_UPD_DONE: begin
                out_load      = out_free;
                tbl_ctl.wr_en = out_free && slot_ok;
                o_fs          = slot_ok && !tbl_rd.present;
                o_ch          = slot_ok && tbl_rd.present &&
                                ((tbl_rd.cell_x != cx_reg) || (tbl_rd.cell_y != div_cell));
            end
            ST_QRY_SCAN: begin
                tbl_ctl.rd_en = issue;
                tbl_rd_addr   = iss_cnt_reg[AW-1:0];
                out_load      = hit && pend_vld_reg && out_free;
                o_slot        = SLOT_W'(pend_idx_reg);
                o_cx          = qx_reg;
                o_cy          = qy_reg;
                o_last        = 1'b0;
            end
            ST_QRY_END: begin
                out_load = out_free;
                o_slot   = pend_vld_reg ? SLOT_W'(pend_idx_reg) : '0;
                o_cx     = qx_reg;
                o_cy     = qy_reg;
                o_em     = !pend_vld_reg;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg    <= s_opcode;
            slot_reg  <= s_actor_slot;
            pos_x_reg <= s_pos_x;
            pos_y_reg <= s_pos_y;
            qx_reg    <= s_query_cell_x;
            qy_reg    <= s_query_cell_y;
        end
        if (state_reg == ST_UPD_Y) begin
            cx_reg <= div_cell;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iss_cnt_reg  <= '0;
            cmp_vld_reg  <= 1'b0;
            cmp_idx_reg  <= '0;
            pend_vld_reg <= 1'b0;
            pend_idx_reg <= '0;
        end else if (accept) begin
            iss_cnt_reg  <= '0;
            cmp_vld_reg  <= 1'b0;
            pend_vld_reg <= 1'b0;
        end else if (state_reg == ST_QRY_SCAN && op_reg == OP_QUERY && !stall) begin
            cmp_vld_reg <= issue;
            cmp_idx_reg <= iss_cnt_reg[AW-1:0];
            if (issue) begin
                iss_cnt_reg <= iss_cnt_reg + 1'b1;
            end
            if (hit) begin
                pend_vld_reg <= 1'b1;
                pend_idx_reg <= cmp_idx_reg;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_slot_reg <= o_slot;
            m_cx_reg   <= o_cx;
            m_cy_reg   <= o_cy;
            m_fs_reg   <= o_fs;
            m_ch_reg   <= o_ch;
            m_em_reg   <= o_em;
            m_last_reg <= o_last;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_member_slot  = m_slot_reg;
    assign m_cell_x       = m_cx_reg;
    assign m_cell_y       = m_cy_reg;
    assign m_first_seen   = m_fs_reg;
    assign m_changed_cell = m_ch_reg;
    assign m_cell_empty   = m_em_reg;
    assign m_last_result  = m_last_reg;

endmodule
